// File: hw/rtl/sync_sum_frame_deframer_assert.svh
// Assertion macros for the sync and checksum frame deframer.
`ifndef SYNC_SUM_FRAME_DEFRAMER_ASSERT_SVH
`define SYNC_SUM_FRAME_DEFRAMER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define SSFD_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("deframer assertion failed");
// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define SSFD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("deframer assertion failed");
`else
`define SSFD_ASSERT_NOW(label, ante, cons)
`define SSFD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: hw/rtl/ssfd_pkg.sv
// Package with constants, types and field layout functions of the deframer.
`timescale 1ns / 1ps
`default_nettype none
package ssfd_pkg;
	localparam logic [7:0] SYNC_FIRST  = 8'hAA;
	localparam logic [7:0] SYNC_SECOND = 8'h55;
	localparam logic [5:0] MODE_MASK   = 6'h3F;
	localparam int FRAME_LEN = 67;
	localparam logic [6:0] SUM_LEN   = 7'd66;
	localparam logic [6:0] MODE_ADDR = 7'd65;
	localparam logic [6:0] LAST_ADDR = 7'd66;
	localparam logic [4:0] MODE_FIELD = 5'd15;
	localparam logic [4:0] SOLN_FIELD = 5'd16;
	localparam logic [4:0] LAST_FIELD = 5'd16;

	typedef struct packed {
		logic [5:0] stable_mode;
		logic       mode_changed;
	} ssfd_mode_status_t;

	function automatic logic [6:0] field_start(input logic [4:0] f);
		logic [6:0] fi;
		fi = {2'b00, f};
		if (f < 5'd2)
			field_start = 7'd9 + (fi << 3);
		else if (f < 5'd9)
			field_start = 7'd25 + ((fi - 7'd2) << 2);
		else if (f < 5'd15)
			field_start = 7'd53 + ((fi - 7'd9) << 1);
		else
			field_start = MODE_ADDR;
	endfunction

	function automatic logic [2:0] field_last_lane(input logic [4:0] f);
		if (f < 5'd2)
			field_last_lane = 3'd7;
		else if (f < 5'd9)
			field_last_lane = 3'd3;
		else if (f < 5'd15)
			field_last_lane = 3'd1;
		else
			field_last_lane = 3'd0;
	endfunction
endpackage
`default_nettype wire

// File: hw/rtl/ssfd_if.sv
// Handshake interfaces for the byte input, configuration and field output channels.
`timescale 1ns / 1ps
`default_nettype none
interface ssfd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface ssfd_cfg_if;
	logic valid;
	logic ready;
	logic receive_enable;
	modport source (output valid, output receive_enable, input ready);
	modport sink (input valid, input receive_enable, output ready);
endinterface

interface ssfd_out_if;
	logic        valid;
	logic        ready;
	logic [4:0]  field_index;
	logic [63:0] field_value;
	logic        is_last;
	logic [5:0]  stable_mode;
	logic        mode_changed;
	modport source (output valid, output field_index, output field_value, output is_last,
		output stable_mode, output mode_changed, input ready);
	modport sink (input valid, input field_index, input field_value, input is_last,
		input stable_mode, input mode_changed, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/ssfd_debounce.sv
// Debounce of the location mode over consecutive emitted frames.
`timescale 1ns / 1ps
`default_nettype none
module ssfd_debounce (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       update,
	input  wire logic [5:0]                 mode,
	output ssfd_pkg::ssfd_mode_status_t     status
);
	import ssfd_pkg::*;

	logic [5:0] stable_q;
	logic [1:0] run_q;
	logic       changed_q;
	logic [1:0] run_inc;

	assign run_inc = (mode != stable_q) ? run_q + 2'd1 : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q  <= '0;
			run_q     <= '0;
			changed_q <= 1'b0;
		end else if (update) begin
			if (run_inc >= 2'd2) begin
				stable_q  <= mode & MODE_MASK;
				run_q     <= '0;
				changed_q <= 1'b1;
			end else begin
				run_q     <= run_inc;
				changed_q <= 1'b0;
			end
		end
	end

	assign status.stable_mode  = stable_q;
	assign status.mode_changed = changed_q;
endmodule
`default_nettype wire

// File: hw/rtl/sync_sum_frame_deframer.sv
// Top level of the sync header frame deframer with 8-bit sum checksum.
// Bytes are taken one per cycle while the field emitter is idle.
// After the checksum byte transfer, field 0 is read in E_READ, passes E_MERGE and is loaded in E_EMIT.
// The 17 fields are emitted through the single read port of the frame memory, one byte a
// cycle in E_READ, with E_MERGE and E_EMIT after each field; E_EMIT waits on result.ready.
// Reset clears control state, the enable and the debounce; the frame memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "sync_sum_frame_deframer_assert.svh"
module sync_sum_frame_deframer (
	input wire logic    clk,
	input wire logic    arst_n,
	ssfd_cfg_if.sink    cfg,
	ssfd_in_if.sink     rx,
	ssfd_out_if.source  result
);
	import ssfd_pkg::*;

	typedef enum logic [2:0] {
		PH_HUNT    = 3'b001,
		PH_SECOND  = 3'b010,
		PH_COLLECT = 3'b100
	} phase_t;

	typedef enum logic [3:0] {
		E_IDLE  = 4'b0001,
		E_READ  = 4'b0010,
		E_MERGE = 4'b0100,
		E_EMIT  = 4'b1000
	} emit_t;

	phase_t            phase_q;
	emit_t             emit_state_q;
	logic              enable_q;
	logic [6:0]        byte_idx_q;
	logic [7:0]        sum_q;
	logic [7:0]        mode_byte_q;
	logic [4:0]        field_q;
	logic [2:0]        lane_q;
	logic [63:0]       acc_q;
	logic              rd_en_s1;
	logic [2:0]        lane_s1;
	logic [7:0]        rd_data_s1;
	logic [7:0]        frame_mem [FRAME_LEN];
	logic              out_valid_q;
	logic [4:0]        out_index_q;
	logic [63:0]       out_value_q;
	logic              out_last_q;
	logic [5:0]        out_mode_q;
	logic              out_changed_q;

	logic              rx_xfer;
	logic              mem_wr;
	logic              start_emit;
	logic              rd_en;
	logic [6:0]        rd_addr;
	logic              load;
	logic              acc_clr;
	logic [63:0]       field_val;
	ssfd_mode_status_t mode_status;

	assign cfg.ready = 1'b1;
	assign rx.ready  = (emit_state_q == E_IDLE);
	assign rx_xfer   = rx.valid && rx.ready;
	assign mem_wr    = rx_xfer && (phase_q == PH_COLLECT);
	assign start_emit = mem_wr && (byte_idx_q == SUM_LEN) && (sum_q == rx.rx_byte) && enable_q;

	assign rd_en   = (emit_state_q == E_READ);
	assign rd_addr = field_start(field_q) + {4'b0000, lane_q};
	assign load    = (emit_state_q == E_EMIT) && (!out_valid_q || result.ready);
	assign acc_clr = start_emit || (load && (field_q != LAST_FIELD));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			enable_q <= 1'b0;
		else if (cfg.valid && cfg.ready)
			enable_q <= cfg.receive_enable;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HUNT;
			byte_idx_q <= '0;
			sum_q      <= '0;
		end else if (rx_xfer) begin
			case (phase_q)
				PH_HUNT: begin
					if (rx.rx_byte == SYNC_FIRST)
						phase_q <= PH_SECOND;
				end
				PH_SECOND: begin
					if (rx.rx_byte == SYNC_SECOND) begin
						phase_q    <= PH_COLLECT;
						byte_idx_q <= '0;
						sum_q      <= '0;
					end else begin
						phase_q <= PH_HUNT;
					end
				end
				PH_COLLECT: begin
					if (byte_idx_q < SUM_LEN) begin
						sum_q      <= sum_q + rx.rx_byte;
						byte_idx_q <= byte_idx_q + 7'd1;
					end else begin
						phase_q    <= PH_HUNT;
						byte_idx_q <= '0;
						sum_q      <= '0;
					end
				end
				default: begin
					phase_q    <= PH_HUNT;
					byte_idx_q <= '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mem_wr && (byte_idx_q == MODE_ADDR))
			mode_byte_q <= rx.rx_byte;
	end

	always_ff @(posedge clk) begin
		if (mem_wr)
			frame_mem[byte_idx_q] <= rx.rx_byte;
		if (rd_en)
			rd_data_s1 <= frame_mem[rd_addr];
	end

	ssfd_debounce u_debounce (
		.clk    (clk),
		.arst_n (arst_n),
		.update (start_emit),
		.mode   (mode_byte_q[5:0]),
		.status (mode_status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_state_q <= E_IDLE;
			field_q      <= '0;
			lane_q       <= '0;
			rd_en_s1     <= 1'b0;
		end else begin
			rd_en_s1 <= rd_en;
			case (emit_state_q)
				E_IDLE: begin
					if (start_emit) begin
						emit_state_q <= E_READ;
						field_q      <= '0;
						lane_q       <= '0;
					end
				end
				E_READ: begin
					if (lane_q == field_last_lane(field_q))
						emit_state_q <= E_MERGE;
					else
						lane_q <= lane_q + 3'd1;
				end
				E_MERGE: emit_state_q <= E_EMIT;
				E_EMIT: begin
					if (load) begin
						if (field_q == LAST_FIELD) begin
							emit_state_q <= E_IDLE;
						end else begin
							emit_state_q <= E_READ;
							field_q      <= field_q + 5'd1;
							lane_q       <= '0;
						end
					end
				end
				default: emit_state_q <= E_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		lane_s1 <= lane_q;
		if (acc_clr)
			acc_q <= '0;
		else if (rd_en_s1)
			acc_q[{lane_s1, 3'b000} +: 8] <= rd_data_s1;
	end

	always_comb begin
		case (field_q)
			MODE_FIELD: field_val = {58'd0, acc_q[5:0]};
			SOLN_FIELD: field_val = {62'd0, acc_q[7:6]};
			default:    field_val = acc_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load)
			out_valid_q <= 1'b1;
		else if (result.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_index_q   <= field_q;
			out_value_q   <= field_val;
			out_last_q    <= (field_q == LAST_FIELD);
			out_mode_q    <= mode_status.stable_mode;
			out_changed_q <= mode_status.mode_changed;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.field_index  = out_index_q;
	assign result.field_value  = out_value_q;
	assign result.is_last      = out_last_q;
	assign result.stable_mode  = out_mode_q;
	assign result.mode_changed = out_changed_q;

	`SSFD_ASSERT_NOW(a_last_is_final_field, result.valid && result.is_last,
		result.field_index == LAST_FIELD)
	`SSFD_ASSERT_NOW(a_emit_starts_on_checksum,
		emit_state_q == E_READ && $past(emit_state_q == E_IDLE),
		$past(phase_q == PH_COLLECT && byte_idx_q == SUM_LEN))
	`SSFD_ASSERT_NOW(a_read_in_frame, rd_en, rd_addr <= LAST_ADDR)
	`SSFD_ASSERT_NEXT(a_lane_in_field, rd_en, lane_s1 <= field_last_lane(field_q))
endmodule
`default_nettype wire
